>>> sv/rbg_pkg.sv
// ----------------------------------------------------------------------------
// rbg_pkg: shared types and constants of the row Gaussian blur
// Field widths, weight register map and the control word that travels from
// the front end through the op queue to the filter back end.
// ----------------------------------------------------------------------------
package rbg_pkg;

	// fixed field widths
	localparam int PIX_W     = 16;
	localparam int WEIGHT_W  = 16;
	localparam int FRAC_BITS = 15;

	// weight registers: centre tap, then one per distance
	localparam int NUM_WEIGHTS = 7;
	localparam int CFG_IDX_W   = 3;
	localparam int NUM_WSLOT   = 2 ** CFG_IDX_W;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'h8000;

	// default build
	localparam int RBG_RADIUS     = 6;
	localparam int RBG_PIXEL_BITS = 16;
	localparam int RBG_QDEPTH     = 4;

	// per-op control for the back end
	typedef struct packed {
		logic emit;   // produce an output for this shift
		logic done;   // last output of the row
		logic clear;  // wipe the tap line after this shift
	} rbg_ctl_t;

endpackage

>>> sv/rbg_if.sv
// ----------------------------------------------------------------------------
// rbg_pix_if / rbg_res_if: pixel and result channels
// Valid/ready channels; an item moves on a rising edge with both high.
// ----------------------------------------------------------------------------
interface rbg_pix_if;
	import rbg_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_in;
	logic [PIX_W-1:0] green_in;
	logic [PIX_W-1:0] blue_in;
	logic             row_end;

	modport source (output valid, red_in, green_in, blue_in, row_end, input ready);
	modport sink   (input valid, red_in, green_in, blue_in, row_end, output ready);
endinterface

interface rbg_res_if;
	import rbg_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_out;
	logic [PIX_W-1:0] green_out;
	logic [PIX_W-1:0] blue_out;
	logic             row_done;

	modport source (output valid, red_out, green_out, blue_out, row_done, input ready);
	modport sink   (input valid, red_out, green_out, blue_out, row_done, output ready);
endinterface

>>> sv/rbg_front.sv
// ----------------------------------------------------------------------------
// rbg_front: pixel intake and row-end sequencer
// Turns each accepted pixel into one shift op; a row-end pixel is followed
// by RADIUS zero shifts that flush the trailing outputs and clear the line.
// ----------------------------------------------------------------------------
module rbg_front #(
	parameter int RADIUS = rbg_pkg::RBG_RADIUS,
	parameter int PW     = rbg_pkg::PIX_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0][PW-1:0]    in_pix,
	input  logic                  in_last,
	input  logic                  q_full,
	output logic                  q_wr,
	output logic [2:0][PW-1:0]    q_pix,
	output rbg_pkg::rbg_ctl_t     q_ctl
);
	import rbg_pkg::*;

	localparam int CW = $clog2(RADIUS + 1);

	typedef enum logic [1:0] {
		ST_RUN   = 2'b01,
		ST_FLUSH = 2'b10
	} rbg_state_t;

	rbg_state_t    state_q;
	logic [CW-1:0] cnt_q;    // columns taken, saturates at RADIUS
	logic [CW-1:0] need_q;   // first flush step that emits
	logic [CW-1:0] step_q;   // current flush step, 1..RADIUS
	logic          take;

	assign in_ready = (state_q == ST_RUN) && !q_full;
	assign take     = in_valid && in_ready;

	// op generation
	always_comb begin
		q_wr  = 1'b0;
		q_pix = in_pix;
		q_ctl = '0;
		case (state_q)
			ST_RUN: begin
				q_wr       = take;
				q_ctl.emit = (cnt_q == CW'(RADIUS));
			end
			ST_FLUSH: begin
				q_wr        = !q_full;
				q_pix       = '0;
				q_ctl.emit  = (step_q >= need_q);
				q_ctl.done  = (step_q == CW'(RADIUS));
				q_ctl.clear = (step_q == CW'(RADIUS));
			end
			default: begin
				q_wr = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			cnt_q   <= '0;
			need_q  <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (take) begin
						if (in_last) begin
							state_q <= ST_FLUSH;
							need_q  <= CW'(RADIUS) - cnt_q;
							cnt_q   <= '0;
							step_q  <= CW'(1);
						end else if (cnt_q != CW'(RADIUS)) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (!q_full) begin
						if (step_q == CW'(RADIUS)) begin
							state_q <= ST_RUN;
						end else begin
							step_q <= step_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

endmodule

>>> sv/rbg_queue.sv
// ----------------------------------------------------------------------------
// rbg_queue: short op queue between front end and filter
// Register-based FIFO; lets intake and filter stall independently.
// ----------------------------------------------------------------------------
module rbg_queue #(
	parameter int W     = 8,
	parameter int DEPTH = rbg_pkg::RBG_QDEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         avail
);
	import rbg_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [NW-1:0] fill_q;
	logic          do_wr;
	logic          do_rd;

	assign full  = (fill_q == NW'(DEPTH));
	assign avail = (fill_q != '0);
	assign rdata = mem_q[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && avail;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + NW'(1);
			end else if (!do_wr && do_rd) begin
				fill_q <= fill_q - NW'(1);
			end
		end
	end

endmodule

>>> sv/rbg_back.sv
// ----------------------------------------------------------------------------
// rbg_back: tap line and symmetric FIR datapath
// Shifts one op per cycle into a 2*RADIUS+1 tap line, folds mirrored taps,
// multiplies by the distance weights, sums in a two-level tree, then rounds
// and saturates. Whole pipe advances together under output back-pressure.
// ----------------------------------------------------------------------------
module rbg_back #(
	parameter int RADIUS     = rbg_pkg::RBG_RADIUS,
	parameter int PIXEL_BITS = rbg_pkg::RBG_PIXEL_BITS,
	parameter int PW         = rbg_pkg::PIX_W
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              q_avail,
	input  logic [2:0][PW-1:0]                                q_pix,
	input  rbg_pkg::rbg_ctl_t                                 q_ctl,
	output logic                                              q_rd,
	input  logic [rbg_pkg::NUM_WSLOT-1:0][rbg_pkg::WEIGHT_W-1:0] wts,
	output logic                                              out_valid,
	input  logic                                              out_ready,
	output logic [rbg_pkg::PIX_W-1:0]                         red_out,
	output logic [rbg_pkg::PIX_W-1:0]                         green_out,
	output logic [rbg_pkg::PIX_W-1:0]                         blue_out,
	output logic                                              out_done
);
	import rbg_pkg::*;

	localparam int NTAP   = 2 * RADIUS + 1;
	localparam int NPROD  = ((RADIUS < NUM_WEIGHTS - 1) ? RADIUS : NUM_WEIGHTS - 1) + 1;
	localparam int NH     = (NPROD + 1) / 2;
	localparam int NPP    = 2 * NH;
	localparam int PAIR_W = PW + 1;
	localparam int PROD_W = PAIR_W + WEIGHT_W;
	localparam int ACC_W  = PROD_W + 3;
	localparam int RND_W  = ACC_W + 1 - FRAC_BITS;
	localparam logic [63:0]      PIX_MAX  = (64'd1 << PIXEL_BITS) - 64'd1;
	localparam logic [ACC_W:0]   RND_HALF = (ACC_W + 1)'(1) << (FRAC_BITS - 1);

	logic                          en;
	logic [NTAP-1:0][2:0][PW-1:0]  tap_q;
	logic [NTAP-1:0][2:0][PW-1:0]  nxt;
	logic [NPP-1:0][2:0][PAIR_W-1:0] pair;

	logic                              v_s1, v_s2, v_s3, v_s4;
	logic                              done_s1, done_s2, done_s3, done_s4;
	logic [NPP-1:0][2:0][PAIR_W-1:0]   pair_s1;
	logic [NPP-1:0][2:0][PROD_W-1:0]   prod_s2;
	logic [NH-1:0][2:0][ACC_W-1:0]     half_s3;
	logic [2:0][ACC_W-1:0]             acc_s4;
	logic [2:0][ACC_W-1:0]             acc_sum;
	logic [2:0][PIX_W-1:0]             res;

	// global advance: the output register is free or being drained
	assign en   = !out_valid || out_ready;
	assign q_rd = en && q_avail;

	// next tap line and folded mirror pairs
	always_comb begin
		nxt[0] = q_pix;
		for (int k = 1; k < NTAP; k++) begin
			nxt[k] = tap_q[k-1];
		end
		for (int d = 0; d < NPP; d++) begin
			for (int ch = 0; ch < 3; ch++) begin
				if (d == 0) begin
					pair[d][ch] = PAIR_W'(nxt[RADIUS][ch]);
				end else if (d < NPROD) begin
					pair[d][ch] = PAIR_W'(nxt[RADIUS-d][ch]) + PAIR_W'(nxt[RADIUS+d][ch]);
				end else begin
					pair[d][ch] = '0;
				end
			end
		end
	end

	// tap line, cleared at row end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (q_rd) begin
			tap_q <= q_ctl.clear ? '0 : nxt;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= q_rd && q_ctl.emit;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			out_valid <= v_s4;
		end
	end

	// tree sum of the pair halves
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			acc_sum[ch] = '0;
			for (int i = 0; i < NH; i++) begin
				acc_sum[ch] = acc_sum[ch] + half_s3[i][ch];
			end
		end
	end

	// round half up, saturate at pixel maximum
	always_comb begin
		logic [ACC_W:0]   rnd_full;
		logic [RND_W-1:0] rnd;
		for (int ch = 0; ch < 3; ch++) begin
			rnd_full = (ACC_W + 1)'(acc_s4[ch]) + RND_HALF;
			rnd      = rnd_full[ACC_W:FRAC_BITS];
			if ((rnd >> PIXEL_BITS) != '0) begin
				res[ch] = PIX_MAX[PIX_W-1:0];
			end else begin
				res[ch] = PIX_W'(rnd);
			end
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			pair_s1 <= pair;
			done_s1 <= q_ctl.done;
			done_s2 <= done_s1;
			done_s3 <= done_s2;
			done_s4 <= done_s3;
			out_done <= done_s4;
			for (int d = 0; d < NPP; d++) begin
				for (int ch = 0; ch < 3; ch++) begin
					prod_s2[d][ch] <= PROD_W'(pair_s1[d][ch]) * PROD_W'(wts[d]);
				end
			end
			for (int i = 0; i < NH; i++) begin
				for (int ch = 0; ch < 3; ch++) begin
					half_s3[i][ch] <= ACC_W'(prod_s2[2*i][ch]) + ACC_W'(prod_s2[2*i+1][ch]);
				end
			end
			acc_s4    <= acc_sum;
			red_out   <= res[0];
			green_out <= res[1];
			blue_out  <= res[2];
		end
	end

endmodule

>>> sv/row_gaussian_blur.sv
// A result reaches the port through the queue, fold, multiply, two adder levels and
// round/saturate registers after the pixel that completes its window is accepted.
// Throughput: one pixel per cycle while the queue has room; a row-end pixel is followed
// by RADIUS zero shifts that the front end issues into the tap line, likewise one per cycle.
// Reset (arst_n low): tap line and column count cleared, centre weight 1.0,
// other weights zero, no results pending.
// ----------------------------------------------------------------------------
// row_gaussian_blur: horizontal symmetric FIR blur over one RGB image row
// Front end classifies pixels into shift ops, a short queue decouples it from
// the filter back end, weights come from a plain write port.
// ----------------------------------------------------------------------------
module row_gaussian_blur #(
	parameter int RADIUS     = rbg_pkg::RBG_RADIUS,
	parameter int PIXEL_BITS = rbg_pkg::RBG_PIXEL_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rbg_pix_if.sink                        pixels,
	rbg_res_if.source                      blurred,
	input  logic                           cfg_we,
	input  logic [rbg_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [rbg_pkg::WEIGHT_W-1:0]   cfg_data
);
	import rbg_pkg::*;

	localparam int PW = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
	localparam int QW = 3 * PW + $bits(rbg_ctl_t);

	logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0] weight_q;
	logic [NUM_WSLOT-1:0][WEIGHT_W-1:0]   wts;
	logic [2:0][PW-1:0]                   in_pix;
	logic [2:0][PW-1:0]                   f_pix;
	rbg_ctl_t                             f_ctl;
	logic                                 f_wr;
	logic                                 q_full;
	logic [QW-1:0]                        q_rdata;
	logic                                 q_avail;
	logic                                 q_rd;
	logic [2:0][PW-1:0]                   b_pix;
	rbg_ctl_t                             b_ctl;

	// weight registers; unused index slot reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= {{(NUM_WEIGHTS - 1) * WEIGHT_W{1'b0}}, WEIGHT_ONE};
		end else if (cfg_we && (cfg_idx < CFG_IDX_W'(NUM_WEIGHTS))) begin
			weight_q[cfg_idx] <= cfg_data;
		end
	end

	assign wts = {{(NUM_WSLOT - NUM_WEIGHTS) * WEIGHT_W{1'b0}}, weight_q};

	// channel bits above the pixel width are dropped
	assign in_pix[0] = pixels.red_in[PW-1:0];
	assign in_pix[1] = pixels.green_in[PW-1:0];
	assign in_pix[2] = pixels.blue_in[PW-1:0];

	rbg_front #(
		.RADIUS (RADIUS),
		.PW     (PW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixels.valid),
		.in_ready (pixels.ready),
		.in_pix   (in_pix),
		.in_last  (pixels.row_end),
		.q_full   (q_full),
		.q_wr     (f_wr),
		.q_pix    (f_pix),
		.q_ctl    (f_ctl)
	);

	rbg_queue #(
		.W     (QW),
		.DEPTH (RBG_QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_wr),
		.wdata  ({f_pix, f_ctl}),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.avail  (q_avail)
	);

	assign b_pix = q_rdata[QW-1:$bits(rbg_ctl_t)];
	assign b_ctl = q_rdata[$bits(rbg_ctl_t)-1:0];

	rbg_back #(
		.RADIUS     (RADIUS),
		.PIXEL_BITS (PIXEL_BITS),
		.PW         (PW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_avail   (q_avail),
		.q_pix     (b_pix),
		.q_ctl     (b_ctl),
		.q_rd      (q_rd),
		.wts       (wts),
		.out_valid (blurred.valid),
		.out_ready (blurred.ready),
		.red_out   (blurred.red_out),
		.green_out (blurred.green_out),
		.blue_out  (blurred.blue_out),
		.out_done  (blurred.row_done)
	);

endmodule

>>> sv/rbg_checker.sv
// ----------------------------------------------------------------------------
// rbg_checker: port-level checks for the row blur
// Watches the handshakes and the row-end sequencing at the top-level ports.
// ----------------------------------------------------------------------------
module rbg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_row_end,
	input logic out_valid,
	input logic out_ready,
	input logic out_row_done
);
	import rbg_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_row_done))
		else $error("result dropped or changed while stalled");

	// row end starts the flush, so intake closes for the next cycle
	a_flush_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_row_end |=> !in_ready)
		else $error("pixel taken during row-end flush");

	// nothing is offered straight out of reset
	a_reset_clean: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid out of reset");

endmodule

bind row_gaussian_blur rbg_checker u_rbg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (pixels.valid),
	.in_ready     (pixels.ready),
	.in_row_end   (pixels.row_end),
	.out_valid    (blurred.valid),
	.out_ready    (blurred.ready),
	.out_row_done (blurred.row_done)
);
